@@ src/hscb_pkg.sv @@
package hscb_pkg;

  // Field widths of the pixel channels and the blend weight.
  localparam int CH_W = 8;
  localparam int WT_W = 9;
  localparam int WT_ONE = 256;

  // Internal HSL formats: hue in degrees with 6 fraction bits, S and L in Q16.
  localparam int H_W = 15;
  localparam int Q_W = 17;
  localparam int QONE = 65536;
  localparam int DEG60 = 3840;
  localparam int DEG360 = 23040;

  // Stages of the pipelined restoring dividers, one quotient bit per stage.
  localparam int DIV_QW = 17;

  // Reciprocals for the constant divisions: ceil(2^32 / 255) for lightness,
  // ceil(2^24 / 15) for the sector component after a shift by 8.
  localparam int L_RECIP = 16843010;
  localparam int X_RECIP = 1118482;

  // Queue depths; each exceeds the latency of the part that feeds it.
  localparam int MID_DEPTH = 32;
  localparam int OUT_DEPTH = 32;

  typedef struct packed {
    logic [CH_W-1:0] first_red;
    logic [CH_W-1:0] first_green;
    logic [CH_W-1:0] first_blue;
    logic [CH_W-1:0] first_alpha;
    logic [CH_W-1:0] second_red;
    logic [CH_W-1:0] second_green;
    logic [CH_W-1:0] second_blue;
    logic [CH_W-1:0] second_alpha;
    logic [WT_W-1:0] blend_weight;
  } pair_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } color_t;

  typedef struct packed {
    logic [H_W-1:0]  h;
    logic [Q_W-1:0]  s;
    logic [Q_W-1:0]  l;
    logic [CH_W-1:0] a;
  } hsla_t;

  typedef struct packed {
    hsla_t           first;
    hsla_t           second;
    logic [WT_W-1:0] weight;
  } mid_t;

endpackage

@@ src/hsl_space_color_blend.sv @@
// HSL-space blend of two RGBA pixels.
// Input side is a queue write port: an item (pair) is taken at a clock edge
// with push high and full low. It carries both pixels and the weight of the
// first pixel in Q1.8; weights above 256 count as 256.
// Result side is a queue read port: while empty is low, blend shows the
// oldest result, and it is removed at an edge with pop high.
// One item per clock is accepted and delivered in steady state while nothing
// stalls. On its way to blend an item passes the classification register,
// the 17 divider stages in the front part (saturation and hue), the storage
// and head registers of the middle queue, five stages in the back part and
// the storage and head registers of the result queue.
// The front part and the back part are parted by a 32-entry middle queue, and
// a 32-entry result queue follows the back part; credit counters admit items
// only when queue space for them is held, so a stalled reader fills the
// queues and then raises full, losing nothing.
// Synchronous reset empties both queues and clears all valid flags; full is
// low and empty is high right after reset.
module hsl_space_color_blend #(
  parameter int MID_DEPTH = hscb_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = hscb_pkg::OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hscb_pkg::pair_t   pair,
  input  logic              pop,
  output logic              empty,
  output hscb_pkg::color_t  blend
);

  logic             mid_wr;
  hscb_pkg::mid_t   mid_in;
  logic [$bits(hscb_pkg::mid_t)-1:0] mid_raw;
  hscb_pkg::mid_t   mid_out;
  logic             mid_empty;
  logic             mid_pop;
  logic             res_wr;
  hscb_pkg::color_t res_in;
  logic [$bits(hscb_pkg::color_t)-1:0] res_raw;
  logic             res_pop;

  // Front part: classification and RGB to HSL.
  hscb_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .pair(pair), .full(full),
    .mid_pop(mid_pop), .mid_wr(mid_wr), .mid_item(mid_in)
  );

  // Middle queue.
  hscb_fifo #(.WIDTH($bits(hscb_pkg::mid_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk(clk), .rst(rst), .wr_en(mid_wr), .wr_data(mid_in),
    .rd_en(mid_pop), .rd_data(mid_raw), .empty(mid_empty)
  );

  assign mid_out = hscb_pkg::mid_t'(mid_raw);

  // Back part: blend and HSL to RGB.
  hscb_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk(clk), .rst(rst), .mid_item(mid_out), .mid_empty(mid_empty),
    .mid_pop(mid_pop), .res_pop(res_pop), .res_wr(res_wr), .res_item(res_in)
  );

  // Result queue.
  assign res_pop = pop && !empty;

  hscb_fifo #(.WIDTH($bits(hscb_pkg::color_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk(clk), .rst(rst), .wr_en(res_wr), .wr_data(res_in),
    .rd_en(res_pop), .rd_data(res_raw), .empty(empty)
  );

  assign blend = hscb_pkg::color_t'(res_raw);

endmodule

@@ src/hscb_div.sv @@
module hscb_div #(
  parameter int NW = 24,
  parameter int DW = 8,
  parameter int QW = hscb_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // Compare width covers the remainder and the divisor at its largest shift.
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] qv  [QW+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qv[0]  = '0;

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int J = QW - 1 - s;
    logic [CW-1:0] shd;
    logic [CW-1:0] rx;

    assign shd = CW'(dv[s]) << J;
    assign rx  = CW'(rem[s]);

    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      if (rx >= shd) begin
        rem[s+1] <= NW'(rx - shd);
        qv[s+1]  <= qv[s] | (QW'(1) << J);
      end else begin
        rem[s+1] <= rem[s];
        qv[s+1]  <= qv[s];
      end
    end
  end

  assign quo = qv[QW];

endmodule

@@ src/hscb_fifo.sv @@
module hscb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hscb_pkg::MID_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [WIDTH-1:0] head;
  logic             head_vld;
  logic             load;

  // The head register takes the oldest stored entry when it is free or being read.
  assign load = (count != '0) && (!head_vld || rd_en);

  // Storage; the writer never exceeds the depth, so no full check is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      head <= mem[rd_ptr];
    end
  end

  // Pointers, fill count of the storage and the head flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      head_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(load);
      if (load) begin
        head_vld <= 1'b1;
      end else if (rd_en) begin
        head_vld <= 1'b0;
      end
    end
  end

  assign rd_data = head;
  assign empty   = !head_vld;

endmodule

@@ src/hscb_front.sv @@
module hscb_front #(
  parameter int MID_DEPTH = hscb_pkg::MID_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hscb_pkg::pair_t     pair,
  output logic                full,
  input  logic                mid_pop,
  output logic                mid_wr,
  output hscb_pkg::mid_t      mid_item
);

  localparam int QW = hscb_pkg::DIV_QW;
  localparam int CW = $clog2(MID_DEPTH + 1);

  typedef struct packed {
    logic [hscb_pkg::H_W-1:0]  base;
    logic                      tneg;
    logic                      gray;
    logic [8:0]                sum;
    logic [hscb_pkg::CH_W-1:0] alpha;
  } pside_t;

  typedef struct packed {
    pside_t                    p1;
    pside_t                    p2;
    logic [hscb_pkg::WT_W-1:0] weight;
  } side_t;

  typedef struct packed {
    logic [23:0] s_num;
    logic [7:0]  s_den;
    logic [19:0] h_num;
    logic [7:0]  h_den;
    pside_t      side;
  } prep_t;

  // Max/min classification of one pixel and the operands of its two divisions.
  function automatic prep_t prep(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic [7:0] a);
    prep_t      p;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    logic [8:0] sum;
    logic [8:0] den;
    logic [8:0] t;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum <= 9'd255) ? sum : 9'd510 - sum;
    if (r >= g && r >= b) begin
      p.side.base = '0;
      t = {1'b0, g} - {1'b0, b};
    end else if (g >= r && g >= b) begin
      p.side.base = hscb_pkg::H_W'(2 * hscb_pkg::DEG60);
      t = {1'b0, b} - {1'b0, r};
    end else begin
      p.side.base = hscb_pkg::H_W'(4 * hscb_pkg::DEG60);
      t = {1'b0, r} - {1'b0, g};
    end
    p.side.tneg  = t[8];
    p.side.gray  = (d == 8'd0);
    p.side.sum   = sum;
    p.side.alpha = a;
    if (t[8]) t = 9'd0 - t;
    p.s_num = {d, 16'd0} + 24'(den[7:1]);
    p.s_den = p.side.gray ? 8'd1 : den[7:0];
    p.h_num = 20'(t[7:0]) * 20'(hscb_pkg::DEG60) + 20'(d[7:1]);
    p.h_den = p.side.gray ? 8'd1 : d;
    return p;
  endfunction

  // Hue from sector base and signed offset, wrapped to positive degrees.
  function automatic logic [hscb_pkg::H_W-1:0] hue(input pside_t sd,
                                                   input logic [QW-1:0] q);
    logic [15:0] mag;
    logic [15:0] bs;
    logic [15:0] h;
    mag = 16'(q[11:0]);
    bs  = 16'(sd.base);
    if (sd.gray) h = '0;
    else if (!sd.tneg) h = bs + mag;
    else if (bs >= mag) h = bs - mag;
    else h = bs + 16'(hscb_pkg::DEG360) - mag;
    return hscb_pkg::H_W'(h);
  endfunction

  // Lightness sum * 65536 / 510, rounded, by reciprocal multiplication.
  function automatic logic [hscb_pkg::Q_W-1:0] lgt(input logic [8:0] sum);
    logic [23:0] n;
    logic [48:0] p;
    n = {sum, 15'd0} + 24'd127;
    p = 49'(n) * 49'(hscb_pkg::L_RECIP);
    return p[48:32];
  endfunction

  logic          accept;
  logic [CW-1:0] cnt;
  prep_t         pa;
  prep_t         pb;
  prep_t         ra;
  prep_t         rb;
  side_t         side [QW+1];
  logic          vld  [QW+1];
  logic [QW-1:0] s1_q, h1_q, s2_q, h2_q;
  logic [hscb_pkg::WT_W-1:0] wsat;

  // Credit count of items between the input and the middle queue's head.
  assign accept = push && !full;
  assign full   = (cnt == CW'(MID_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(accept) - CW'(mid_pop);
    end
  end

  // Classification stage.
  assign pa   = prep(pair.first_red, pair.first_green, pair.first_blue, pair.first_alpha);
  assign pb   = prep(pair.second_red, pair.second_green, pair.second_blue,
                     pair.second_alpha);
  assign wsat = (pair.blend_weight > hscb_pkg::WT_W'(hscb_pkg::WT_ONE)) ?
                hscb_pkg::WT_W'(hscb_pkg::WT_ONE) : pair.blend_weight;

  // Side data travels alongside the dividers.
  always_ff @(posedge clk) begin
    ra <= pa;
    rb <= pb;
    side[0] <= '{p1: pa.side, p2: pb.side, weight: wsat};
    for (int i = 1; i <= QW; i++) begin
      side[i] <= side[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QW; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= accept;
      for (int i = 1; i <= QW; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Saturation and hue dividers for both pixels.
  hscb_div #(.NW(24), .DW(8), .QW(QW)) u_s1 (.clk(clk), .num(ra.s_num), .den(ra.s_den),
                                             .quo(s1_q));
  hscb_div #(.NW(20), .DW(8), .QW(QW)) u_h1 (.clk(clk), .num(ra.h_num), .den(ra.h_den),
                                             .quo(h1_q));
  hscb_div #(.NW(24), .DW(8), .QW(QW)) u_s2 (.clk(clk), .num(rb.s_num), .den(rb.s_den),
                                             .quo(s2_q));
  hscb_div #(.NW(20), .DW(8), .QW(QW)) u_h2 (.clk(clk), .num(rb.h_num), .den(rb.h_den),
                                             .quo(h2_q));

  // Assemble the HSLA pair for the middle queue.
  assign mid_wr = vld[QW];
  always_comb begin
    mid_item.first.h  = hue(side[QW].p1, h1_q);
    mid_item.first.s  = side[QW].p1.gray ? '0 : hscb_pkg::Q_W'(s1_q);
    mid_item.first.l  = lgt(side[QW].p1.sum);
    mid_item.first.a  = side[QW].p1.alpha;
    mid_item.second.h = hue(side[QW].p2, h2_q);
    mid_item.second.s = side[QW].p2.gray ? '0 : hscb_pkg::Q_W'(s2_q);
    mid_item.second.l = lgt(side[QW].p2.sum);
    mid_item.second.a = side[QW].p2.alpha;
    mid_item.weight   = side[QW].weight;
  end

endmodule

@@ src/hscb_back.sv @@
module hscb_back #(
  parameter int OUT_DEPTH = hscb_pkg::OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  hscb_pkg::mid_t    mid_item,
  input  logic              mid_empty,
  output logic              mid_pop,
  input  logic              res_pop,
  output logic              res_wr,
  output hscb_pkg::color_t  res_item
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int SW = hscb_pkg::Q_W;

  typedef struct packed {
    logic [SW-1:0]             c;
    logic [2:0]                sec;
    logic [SW-1:0]             l;
    logic [hscb_pkg::CH_W-1:0] a;
  } xside_t;

  // Weighted mix with half-up rounding.
  function automatic logic [SW-1:0] mix(input logic [hscb_pkg::WT_W-1:0] w,
                                        input logic [SW-1:0] x1,
                                        input logic [SW-1:0] x2);
    logic [26:0] acc;
    acc = 27'(w) * 27'(x1) +
          27'(hscb_pkg::WT_W'(hscb_pkg::WT_ONE) - w) * 27'(x2) + 27'd128;
    return acc[24:8];
  endfunction

  // Doubled channel value to a byte, rounded and clamped.
  function automatic logic [7:0] to_byte(input logic signed [20:0] v);
    logic [28:0] p;
    logic [11:0] q;
    if (v <= 0) return 8'd0;
    p = 29'(v) * 29'd255 + 29'd65536;
    q = p[28:17];
    return (q > 12'd255) ? 8'd255 : q[7:0];
  endfunction

  logic          out_take;
  logic [CW-1:0] cnt;

  logic          v1, v2, v3, v4, v5;
  logic [SW-1:0] h1, s1, l1, s2, l2, k2, c3, l3, x5;
  logic [7:0]    a1, a2, a3;
  logic [11:0]   g2, g3;
  logic [2:0]    sec2, sec3;
  logic [2:0]    sec_c;
  logic [14:0]   hm_c;
  logic [17:0]   l2x;
  logic [33:0]   sk;
  logic [27:0]   x_num;
  logic [40:0]   xp;
  xside_t        xs4;
  xside_t        xs5;

  // Credit count of items between the middle queue's head and the result reader.
  assign mid_pop = !mid_empty && (cnt != CW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(mid_pop) - CW'(res_pop);
    end
  end

  // Blend stage.
  always_ff @(posedge clk) begin
    h1 <= mix(mid_item.weight, SW'(mid_item.first.h), SW'(mid_item.second.h));
    s1 <= mix(mid_item.weight, mid_item.first.s, mid_item.second.s);
    l1 <= mix(mid_item.weight, mid_item.first.l, mid_item.second.l);
    a1 <= 8'(mix(mid_item.weight, SW'(mid_item.first.a), SW'(mid_item.second.a)));
  end

  // Sector of the hue and the chroma scale from lightness.
  always_comb begin
    if (h1 < SW'(hscb_pkg::DEG60)) begin
      sec_c = 3'd0;
      hm_c  = 15'(h1);
    end else if (h1 < SW'(2 * hscb_pkg::DEG60)) begin
      sec_c = 3'd1;
      hm_c  = 15'(h1 - SW'(hscb_pkg::DEG60));
    end else if (h1 < SW'(3 * hscb_pkg::DEG60)) begin
      sec_c = 3'd2;
      hm_c  = 15'(h1 - SW'(2 * hscb_pkg::DEG60));
    end else if (h1 < SW'(4 * hscb_pkg::DEG60)) begin
      sec_c = 3'd3;
      hm_c  = 15'(h1 - SW'(3 * hscb_pkg::DEG60));
    end else if (h1 < SW'(5 * hscb_pkg::DEG60)) begin
      sec_c = 3'd4;
      hm_c  = 15'(h1 - SW'(4 * hscb_pkg::DEG60));
    end else begin
      sec_c = 3'd5;
      hm_c  = 15'(h1 - SW'(5 * hscb_pkg::DEG60));
    end
  end

  assign l2x = {l1, 1'b0};

  always_ff @(posedge clk) begin
    k2   <= (l2x >= 18'(hscb_pkg::QONE)) ? SW'(18'(2 * hscb_pkg::QONE) - l2x) : SW'(l2x);
    g2   <= sec_c[0] ? 12'(15'(hscb_pkg::DEG60) - hm_c) : 12'(hm_c);
    sec2 <= sec_c;
    s2   <= s1;
    l2   <= l1;
    a2   <= a1;
  end

  // Chroma.
  assign sk = 34'(s2) * 34'(k2) + 34'd32768;

  always_ff @(posedge clk) begin
    c3   <= sk[32:16];
    g3   <= g2;
    sec3 <= sec2;
    l3   <= l2;
    a3   <= a2;
  end

  // Second component numerator, then division by one sector width as a shift
  // by 8 and a reciprocal multiplication for the remaining factor of 15.
  assign xp = 41'(x_num[27:8]) * 41'(hscb_pkg::X_RECIP);

  always_ff @(posedge clk) begin
    x_num <= 28'(c3) * 28'(g3) + 28'(hscb_pkg::DEG60 / 2);
    xs4   <= '{c: c3, sec: sec3, l: l3, a: a3};
    x5    <= xp[40:24];
    xs5   <= xs4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= mid_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Sector placement of chroma and second component, then bytes.
  always_comb begin
    logic signed [20:0] m2;
    logic signed [20:0] c2x;
    logic signed [20:0] x2x;
    logic signed [20:0] rr;
    logic signed [20:0] gg;
    logic signed [20:0] bb;
    m2  = $signed(21'({xs5.l, 1'b0})) - $signed(21'(xs5.c));
    c2x = $signed(21'({xs5.c, 1'b0}));
    x2x = $signed(21'({x5, 1'b0}));
    rr  = m2;
    gg  = m2;
    bb  = m2;
    case (xs5.sec)
      3'd0: begin rr = m2 + c2x; gg = m2 + x2x; end
      3'd1: begin rr = m2 + x2x; gg = m2 + c2x; end
      3'd2: begin gg = m2 + c2x; bb = m2 + x2x; end
      3'd3: begin gg = m2 + x2x; bb = m2 + c2x; end
      3'd4: begin rr = m2 + x2x; bb = m2 + c2x; end
      default: begin rr = m2 + c2x; bb = m2 + x2x; end
    endcase
    res_item.out_red   = to_byte(rr);
    res_item.out_green = to_byte(gg);
    res_item.out_blue  = to_byte(bb);
    res_item.out_alpha = xs5.a;
  end

  assign res_wr = v5;

endmodule
